/* hw/rtl/block_remap_hash_table_core_macros.svh */
// Assertion macros for the block remap table.
`ifndef BLOCK_REMAP_HASH_TABLE_CORE_MACROS_SVH
`define BLOCK_REMAP_HASH_TABLE_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BRHT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// A signal holds its value on the edge after the condition is seen.
`define BRHT_ASSERT_STABLE(label, clk, rst_n, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
		else $error(msg);
`endif

/* hw/rtl/brht_pkg.sv */
//------------------------------------------------------------------------------
// Block remap table package
// Widths, kind and operation codes shared by the block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package brht_pkg;
	localparam int TABLE_BITS = 10;
	localparam int TABLE_SIZE = 1 << TABLE_BITS;
	localparam int CNT_W = TABLE_BITS + 1;
	localparam logic [31:0] NO_BLOCK = 32'hffffffff;

	typedef logic [TABLE_BITS-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic [1:0] KIND_EMPTY = 2'd0;
	localparam logic [1:0] KIND_LIVE  = 2'd1;
	localparam logic [1:0] KIND_FREED = 2'd2;
	localparam logic [1:0] KIND_DEAD  = 2'd3;

	localparam logic [2:0] FN_LOOKUP = 3'd0;
	localparam logic [2:0] FN_WANT   = 3'd1;
	localparam logic [2:0] FN_TRIM   = 3'd2;
	localparam logic [2:0] FN_CLEAR  = 3'd3;
	localparam logic [2:0] FN_READ   = 3'd4;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] block;
		logic [31:0] trim_limit;
		idx_t        slot;
		idx_t        home;
	} cmd_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] journal_block;
		logic        status;
		logic [31:0] slot_key;
		logic [31:0] slot_jblock;
		logic [1:0]  slot_kind;
	} res_t;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(res_t);
	localparam int LIM_W = 16 + 3;
	// 5*(TABLE_SIZE-1) compared against 6*live_count
	localparam logic [LIM_W-1:0] LOAD_LIM = LIM_W'(5 * (TABLE_SIZE - 1));
endpackage

/* hw/rtl/brht_if.sv */
//------------------------------------------------------------------------------
// Valid/ready channel interfaces
// Request and result channels of the block remap table.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
interface brht_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [31:0] block;
	logic [31:0] trim_limit;
	logic [9:0]  slot_index;
	modport source (output valid, func, block, trim_limit, slot_index, input ready);
	modport sink (input valid, func, block, trim_limit, slot_index, output ready);
endinterface

interface brht_res_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [31:0] journal_block;
	logic        status;
	logic [31:0] slot_key;
	logic [31:0] slot_jblock;
	logic [1:0]  slot_kind;
	modport source (output valid, hit, journal_block, status, slot_key, slot_jblock,
		slot_kind, input ready);
	modport sink (input valid, hit, journal_block, status, slot_key, slot_jblock,
		slot_kind, output ready);
endinterface

/* hw/rtl/block_remap_hash_table_core.sv */
// Lookup and want probe slots from the home slot on; an insert adds the freed block
// scan. Trim walks all 1024 slots, clear rewrites every slot kind, read slot reads one
// slot. One request is in the engine at a time: a new one is taken only once the
// result of the last has been accepted.
// Reset clears counts and the journal end at once, then a clearing pass empties every
// slot kind before the first request is taken.
//------------------------------------------------------------------------------
// Block remap table core
// Linearly probed hash table mapping data blocks to journal blocks.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module block_remap_hash_table_core import brht_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	brht_req_if.sink   req,
	brht_res_if.source res
);
	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	brht_front u_front (.clk(clk), .arst_n(arst_n), .req(req), .cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop), .cmd(cmd));
	brht_engine u_engine (.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop), .cmd(cmd), .res(res));
endmodule

/* hw/rtl/brht_ram.sv */
//------------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered data.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module brht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* hw/rtl/brht_front.sv */
//------------------------------------------------------------------------------
// Request front end
// Accepts requests, computes the home slot and queues them for the engine.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module brht_front import brht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	brht_req_if.sink    req,
	output logic        cmd_valid,
	input  logic        cmd_pop,
	output cmd_t        cmd
);
	cmd_t     q_q [2];
	logic     wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t     in_c;
	logic     push;

	assign req.ready = (cnt_q != 2'd2);
	assign push = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rp_q];

	always_comb begin
		in_c.func = req.func;
		in_c.block = req.block;
		in_c.trim_limit = req.trim_limit;
		in_c.slot = req.slot_index[TABLE_BITS-1:0];
		in_c.home = idx_t'(req.block ^ (req.block >> TABLE_BITS));
	end

	always_ff @(posedge clk) begin
		if (push)
			q_q[wp_q] <= in_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (cmd_pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end
endmodule

/* hw/rtl/brht_engine.sv */
//------------------------------------------------------------------------------
// Table engine
// Probes, reads, inserts, trims and clears the table one slot per step.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module brht_engine import brht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_pop,
	input  cmd_t        cmd,
	brht_res_if.source  res
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_RD    = 10'b0000000010,
		S_CHK   = 10'b0000000100,
		S_INS   = 10'b0000001000,
		S_SRD   = 10'b0000010000,
		S_SCHK  = 10'b0000100000,
		S_WR    = 10'b0001000000,
		S_SWEEP = 10'b0010000000,
		S_OUT   = 10'b0100000000,
		S_CLR   = 10'b1000000000
	} state_t;

	state_t      st_q;
	cmd_t        c_q;
	idx_t        idx_q, chosen_q;
	cnt_t        n_q, scan_q, fss_q, live_q;
	logic        chosen_ok_q, sw_rd_q, sw_last_q;
	logic [31:0] jend_q, jb_q;
	res_t        out_q;
	logic        out_v_q;
	idx_t        sw_idx_q;
	idx_t        clr_idx_q;
	logic        clr_rsp_q;

	logic        we_k;
	idx_t        waddr, raddr;
	logic [31:0] wkey, wjb, rkey, rjb;
	logic        we_kd;
	idx_t        kaddr;
	logic [1:0]  kdata, rkind;
	logic [LIM_W-1:0] six_live;

	assign six_live = LIM_W'(live_q) * LIM_W'(6);

	brht_ram #(.WIDTH(32), .DEPTH(TABLE_SIZE)) u_key (.clk(clk), .we(we_k),
		.waddr(waddr), .wdata(wkey), .raddr(raddr), .rdata(rkey));
	brht_ram #(.WIDTH(32), .DEPTH(TABLE_SIZE)) u_jb (.clk(clk), .we(we_k),
		.waddr(waddr), .wdata(wjb), .raddr(raddr), .rdata(rjb));
	brht_ram #(.WIDTH(2), .DEPTH(TABLE_SIZE)) u_kind (.clk(clk), .we(we_kd),
		.waddr(kaddr), .wdata(kdata), .raddr(raddr), .rdata(rkind));

	assign cmd_pop = (st_q == S_IDLE) && cmd_valid && !out_v_q;
	assign res.valid = out_v_q;
	assign res.hit = out_q.hit;
	assign res.journal_block = out_q.journal_block;
	assign res.status = out_q.status;
	assign res.slot_key = out_q.slot_key;
	assign res.slot_jblock = out_q.slot_jblock;
	assign res.slot_kind = out_q.slot_kind;

	always_comb begin
		we_k = (st_q == S_WR);
		waddr = chosen_q;
		wkey = c_q.block;
		wjb = jb_q;
		case (st_q)
			S_IDLE:  raddr = (cmd.func == FN_READ) ? cmd.slot : cmd.home;
			S_SRD:   raddr = scan_q[TABLE_BITS-1:0];
			S_SWEEP: raddr = sw_idx_q;
			default: raddr = idx_q;
		endcase
	end

	always_comb begin
		we_kd = 1'b0;
		kaddr = chosen_q;
		kdata = KIND_EMPTY;
		case (st_q)
			S_SCHK: begin
				we_kd = (rkind == KIND_FREED);
				kaddr = scan_q[TABLE_BITS-1:0];
				kdata = KIND_DEAD;
			end
			S_WR: begin
				we_kd = 1'b1;
				kdata = KIND_LIVE;
			end
			S_SWEEP: begin
				we_kd = sw_rd_q && rkind == KIND_LIVE && rkey >= c_q.trim_limit;
				kaddr = idx_q;
				kdata = KIND_FREED;
			end
			S_CLR: begin
				we_kd = 1'b1;
				kaddr = clr_idx_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			out_v_q <= 1'b0;
			live_q <= '0;
			fss_q <= cnt_t'(TABLE_SIZE);
			jend_q <= '0;
			clr_idx_q <= '0;
			clr_rsp_q <= 1'b0;
		end else begin
			if (res.valid && res.ready)
				out_v_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (cmd_pop) begin
						c_q <= cmd;
						idx_q <= (cmd.func == FN_READ) ? cmd.slot : cmd.home;
						n_q <= '0;
						chosen_ok_q <= 1'b0;
						out_q <= '0;
						sw_idx_q <= '0;
						sw_rd_q <= 1'b0;
						sw_last_q <= 1'b0;
						case (cmd.func)
							FN_LOOKUP, FN_WANT, FN_READ: st_q <= S_RD;
							FN_TRIM: st_q <= S_SWEEP;
							FN_CLEAR: begin
								live_q <= '0;
								fss_q <= cnt_t'(TABLE_SIZE);
								jend_q <= '0;
								clr_idx_q <= '0;
								clr_rsp_q <= 1'b1;
								st_q <= S_CLR;
							end
							default: st_q <= S_OUT;
						endcase
					end
				end
				S_RD: st_q <= S_CHK;
				S_CHK: begin
					if (c_q.func == FN_READ) begin
						out_q.slot_kind <= rkind;
						out_q.slot_key <= (rkind == KIND_LIVE) ? rkey : '0;
						out_q.slot_jblock <= (rkind == KIND_EMPTY) ? '0 : rjb;
						st_q <= S_OUT;
					end else if (rkind == KIND_LIVE && rkey == c_q.block) begin
						out_q.hit <= 1'b1;
						out_q.journal_block <= rjb;
						st_q <= S_OUT;
					end else begin
						if (rkind != KIND_LIVE && !chosen_ok_q) begin
							chosen_ok_q <= 1'b1;
							chosen_q <= idx_q;
						end
						if (rkind == KIND_EMPTY || n_q == cnt_t'(TABLE_SIZE - 1))
							st_q <= (c_q.func == FN_WANT) ? S_INS : S_OUT;
						else begin
							idx_q <= idx_q + 1'b1;
							n_q <= n_q + 1'b1;
							st_q <= S_RD;
						end
					end
				end
				S_INS: begin
					scan_q <= fss_q;
					if (six_live > LOAD_LIM || !chosen_ok_q) begin
						out_q.status <= 1'b1;
						st_q <= S_OUT;
					end else if (fss_q < cnt_t'(TABLE_SIZE))
						st_q <= S_SRD;
					else if (jend_q == NO_BLOCK) begin
						out_q.status <= 1'b1;
						st_q <= S_OUT;
					end else begin
						jb_q <= jend_q;
						jend_q <= jend_q + 1'b1;
						st_q <= S_WR;
					end
				end
				S_SRD: begin
					if (scan_q == cnt_t'(TABLE_SIZE)) begin
						fss_q <= scan_q;
						if (jend_q == NO_BLOCK) begin
							out_q.status <= 1'b1;
							st_q <= S_OUT;
						end else begin
							jb_q <= jend_q;
							jend_q <= jend_q + 1'b1;
							st_q <= S_WR;
						end
					end else
						st_q <= S_SCHK;
				end
				S_SCHK: begin
					if (rkind == KIND_FREED) begin
						fss_q <= scan_q;
						jb_q <= rjb;
						st_q <= S_WR;
					end else begin
						scan_q <= scan_q + 1'b1;
						st_q <= S_SRD;
					end
				end
				S_WR: begin
					live_q <= live_q + 1'b1;
					out_q.journal_block <= jb_q;
					st_q <= S_OUT;
				end
				S_SWEEP: begin
					sw_rd_q <= !sw_last_q;
					if (!sw_last_q) begin
						idx_q <= sw_idx_q;
						sw_idx_q <= sw_idx_q + 1'b1;
						sw_last_q <= (sw_idx_q == idx_t'(TABLE_SIZE - 1));
					end
					if (sw_rd_q && rkind == KIND_LIVE && rkey >= c_q.trim_limit) begin
						if (cnt_t'(idx_q) < fss_q)
							fss_q <= cnt_t'(idx_q);
						if (live_q != '0)
							live_q <= live_q - 1'b1;
					end
					if (sw_last_q && sw_rd_q)
						st_q <= S_OUT;
				end
				S_CLR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == idx_t'(TABLE_SIZE - 1))
						st_q <= clr_rsp_q ? S_OUT : S_IDLE;
				end
				S_OUT: begin
					out_v_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* hw/rtl/brht_checker.sv */
//------------------------------------------------------------------------------
// Block remap table checker
// Port level properties of the core.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "block_remap_hash_table_core_macros.svh"
module brht_checker import brht_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        hit,
	input logic [31:0] journal_block,
	input logic        status,
	input logic [31:0] slot_key,
	input logic [1:0]  slot_kind
);
	`BRHT_ASSERT(a_hold, clk, arst_n, res_valid && !res_ready |=> res_valid, "result dropped")
	`BRHT_ASSERT(a_hit_ok, clk, arst_n, res_valid && hit |-> !status, "hit with full status")
	`BRHT_ASSERT(a_key, clk, arst_n, res_valid && slot_kind != KIND_LIVE |-> slot_key == '0, "key")
	`BRHT_ASSERT_STABLE(a_jb, clk, arst_n, res_valid && !res_ready, journal_block, "jb moved")
endmodule

bind block_remap_hash_table_core brht_checker u_chk (.clk(clk), .arst_n(arst_n),
	.res_valid(res.valid), .res_ready(res.ready), .hit(res.hit),
	.journal_block(res.journal_block), .status(res.status),
	.slot_key(res.slot_key), .slot_kind(res.slot_kind));

/* tb/sv/block_remap_hash_table_core_tb.sv */
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Block remap table core testbench
// Sends lookup, want, trim, clear, read slot and unused code requests over the
// request channel and checks every result against a model of the hash table, the
// freed block scan and the journal end kept here. Directed cases come first, then
// a fill to the load limit and a random mix; the first 760 requests see stalls.
//------------------------------------------------------------------------------
module block_remap_hash_table_core_tb;
	import brht_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;

	brht_req_if req ();
	brht_res_if res ();

	block_remap_hash_table_core i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.res   (res.source)
	);

	logic [1:0]  tbl_kind [TABLE_SIZE];
	logic [31:0] tbl_key [TABLE_SIZE];
	logic [31:0] tbl_jb [TABLE_SIZE];
	int unsigned n_live;
	int unsigned scan_from;
	logic [31:0] jend;

	res_t        pending_res [$];
	int unsigned n_sent;
	int unsigned n_errors;
	int unsigned src_idle;
	int unsigned snk_idle;
	int unsigned quiet_cycles;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [9:0] home_of(input logic [31:0] key);
		return key[9:0] ^ key[19:10];
	endfunction

	function automatic void table_reset();
		for (int i = 0; i < TABLE_SIZE; i++) begin
			tbl_kind[i] = KIND_EMPTY;
			tbl_key[i] = '0;
			tbl_jb[i] = '0;
		end
		n_live = 0;
		scan_from = TABLE_SIZE;
		jend = '0;
	endfunction

	function automatic bit find_mapping(input logic [31:0] key, output logic [31:0] jb);
		logic [9:0] idx;
		idx = home_of(key);
		jb = '0;
		for (int n = 0; n < TABLE_SIZE; n++) begin
			if (tbl_kind[idx] == KIND_EMPTY)
				return 1'b0;
			if (tbl_kind[idx] == KIND_LIVE && tbl_key[idx] == key) begin
				jb = tbl_jb[idx];
				return 1'b1;
			end
			idx = idx + 10'd1;
		end
		return 1'b0;
	endfunction

	function automatic bit insert_mapping(input logic [31:0] key, output logic [31:0] jb);
		logic [9:0]  idx;
		bit          slot_ok;
		int unsigned found;
		int unsigned i;
		jb = '0;
		slot_ok = 1'b0;
		found = TABLE_SIZE;
		if (6 * n_live > 5 * (TABLE_SIZE - 1))
			return 1'b1;
		idx = home_of(key);
		for (int n = 0; n < TABLE_SIZE; n++) begin
			if (tbl_kind[idx] != KIND_LIVE) begin
				slot_ok = 1'b1;
				break;
			end
			idx = idx + 10'd1;
		end
		if (!slot_ok)
			return 1'b1;
		if (scan_from < TABLE_SIZE) begin
			for (i = scan_from; i < TABLE_SIZE; i++)
				if (tbl_kind[i] == KIND_FREED)
					break;
			scan_from = i;
			found = i;
		end
		if (found < TABLE_SIZE) begin
			jb = tbl_jb[found];
			tbl_kind[found] = KIND_DEAD;
			tbl_key[found] = '0;
		end else begin
			if (jend == NO_BLOCK)
				return 1'b1;
			jb = jend;
			jend = jend + 32'd1;
		end
		tbl_key[idx] = key;
		tbl_jb[idx] = jb;
		tbl_kind[idx] = KIND_LIVE;
		n_live++;
		return 1'b0;
	endfunction

	function automatic res_t predict_result(input logic [2:0] func, input logic [31:0] block,
		input logic [31:0] limit, input logic [9:0] sidx);
		res_t        r;
		logic [31:0] jb;
		r = '0;
		case (func)
			FN_LOOKUP: begin
				if (find_mapping(block, jb)) begin
					r.hit = 1'b1;
					r.journal_block = jb;
				end
			end
			FN_WANT: begin
				if (find_mapping(block, jb)) begin
					r.hit = 1'b1;
					r.journal_block = jb;
				end else if (insert_mapping(block, jb)) begin
					r.status = 1'b1;
				end else begin
					r.journal_block = jb;
				end
			end
			FN_TRIM: begin
				for (int i = 0; i < TABLE_SIZE; i++) begin
					if (tbl_kind[i] == KIND_LIVE && tbl_key[i] >= limit) begin
						tbl_kind[i] = KIND_FREED;
						tbl_key[i] = '0;
						if (i < scan_from)
							scan_from = i;
						if (n_live > 0)
							n_live--;
					end
				end
			end
			FN_CLEAR: table_reset();
			FN_READ: begin
				r.slot_kind = tbl_kind[sidx];
				r.slot_key = (tbl_kind[sidx] == KIND_LIVE) ? tbl_key[sidx] : '0;
				r.slot_jblock = (tbl_kind[sidx] == KIND_EMPTY) ? '0 : tbl_jb[sidx];
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
		n_errors++;
	endtask

	task automatic send_request(input logic [2:0] func, input logic [31:0] block,
		input logic [31:0] limit, input logic [9:0] sidx);
		bit taken;
		if ($urandom_range(99) < src_idle) begin
			req.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle);
		end
		req.valid <= 1'b1;
		req.func <= func;
		req.block <= block;
		req.trim_limit <= limit;
		req.slot_index <= sidx;
		do begin
			@(negedge clk);
			taken = req.ready;
			@(posedge clk);
		end while (!taken);
		pending_res.push_back(predict_result(func, block, limit, sidx));
		n_sent++;
		if (n_sent < 380) begin
			src_idle = 24;
			snk_idle = 80;
		end else if (n_sent < 760) begin
			src_idle = 80;
			snk_idle = 24;
		end else begin
			src_idle = 0;
			snk_idle = 0;
		end
	endtask

	initial begin
		res_t want;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (res.valid && res.ready) begin
				if (pending_res.size() == 0) begin
					$display("[%0t] result with no request outstanding", $realtime);
					n_errors++;
				end else begin
					want = pending_res.pop_front();
					if (res.hit !== want.hit)
						report_mismatch("hit", res.hit, want.hit);
					if (res.journal_block !== want.journal_block)
						report_mismatch("journal_block", res.journal_block, want.journal_block);
					if (res.status !== want.status)
						report_mismatch("status", res.status, want.status);
					if (res.slot_key !== want.slot_key)
						report_mismatch("slot_key", res.slot_key, want.slot_key);
					if (res.slot_jblock !== want.slot_jblock)
						report_mismatch("slot_jblock", res.slot_jblock, want.slot_jblock);
					if (res.slot_kind !== want.slot_kind)
						report_mismatch("slot_kind", res.slot_kind, want.slot_kind);
				end
			end
			@(posedge clk);
			res.ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if ((req.valid && req.ready) || (res.valid && res.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("block_remap_hash_table_core verification failed");
				$finish;
			end
		end
	end

	task automatic test_directed();
		send_request(FN_LOOKUP, 32'd0, 32'd0, 10'd0);
		send_request(FN_READ, 32'd0, 32'd0, 10'd0);
		send_request(FN_WANT, 32'd0, 32'd0, 10'd0);
		send_request(FN_WANT, 32'hfffffffe, 32'd0, 10'd0);
		send_request(FN_WANT, 32'd1, 32'd0, 10'd0);
		send_request(FN_WANT, 32'd1024, 32'd0, 10'd0);
		send_request(FN_WANT, 32'd1025, 32'd0, 10'd0);
		send_request(FN_WANT, 32'd1, 32'd0, 10'd0);
		send_request(FN_LOOKUP, 32'hfffffffe, 32'd0, 10'd0);
		send_request(FN_LOOKUP, 32'd1024, 32'hffffffff, 10'd1023);
		send_request(FN_TRIM, 32'd0, 32'hffffffff, 10'd0);
		send_request(FN_TRIM, 32'hffffffff, 32'd1024, 10'd1023);
		send_request(FN_READ, 32'd0, 32'd0, 10'd2);
		send_request(FN_LOOKUP, 32'd1024, 32'd0, 10'd0);
		send_request(FN_WANT, 32'd1026, 32'd0, 10'd0);
		send_request(FN_WANT, 32'd1024, 32'd0, 10'd0);
		send_request(FN_WANT, 32'd5000, 32'd0, 10'd0);
		for (int i = 0; i < 4; i++)
			send_request(FN_READ, 32'd0, 32'd0, 10'(i));
		send_request(FN_READ, 32'd0, 32'd0, 10'd1023);
		send_request(3'd5, 32'hffffffff, 32'hffffffff, 10'h3ff);
		send_request(3'd7, 32'd0, 32'd0, 10'd0);
		send_request(FN_CLEAR, 32'd0, 32'd0, 10'd0);
		send_request(FN_READ, 32'd0, 32'd0, 10'd1);
	endtask

	task automatic test_fill_to_limit();
		for (int i = 0; i < 860; i++)
			send_request(FN_WANT, 32'(i * 7 + 100000), 32'd0, 10'($urandom));
		send_request(FN_LOOKUP, 32'd100007, 32'd0, 10'd0);
		send_request(FN_TRIM, 32'd0, 32'(102000 + $urandom_range(2000)), 10'd0);
		for (int i = 0; i < 6; i++)
			send_request(FN_WANT, 32'(200000 + i), 32'd0, 10'd0);
		send_request(FN_CLEAR, 32'd0, 32'd0, 10'd0);
	endtask

	task automatic test_random_mix();
		logic [31:0] key;
		logic [31:0] limit;
		int unsigned pick;
		for (int i = 0; i < 255; i++) begin
			pick = $urandom_range(3);
			if (pick == 0)
				key = $urandom;
			else if (pick == 1)
				key = $urandom_range(63);
			else
				key = {12'd0, 10'($urandom_range(3)), 10'($urandom_range(7))};
			if (key == 32'hffffffff)
				key = 32'hfffffffe;
			limit = $urandom_range(1) ? 32'($urandom_range(64)) : $urandom;
			pick = $urandom_range(99);
			if (pick < 48)
				send_request(FN_WANT, key, $urandom, 10'($urandom));
			else if (pick < 72)
				send_request(FN_LOOKUP, key, $urandom, 10'($urandom));
			else if (pick < 88)
				send_request(FN_READ, $urandom, $urandom, 10'($urandom));
			else if (pick < 95)
				send_request(FN_TRIM, $urandom, limit, 10'($urandom));
			else if (pick < 97)
				send_request(FN_CLEAR, $urandom, $urandom, 10'($urandom));
			else
				send_request(3'($urandom_range(7, 5)), $urandom, $urandom, 10'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.func = '0;
		req.block = '0;
		req.trim_limit = '0;
		req.slot_index = '0;
		n_sent = 0;
		n_errors = 0;
		quiet_cycles = 0;
		src_idle = 24;
		snk_idle = 80;
		table_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_to_limit();
		test_random_mix();
		req.valid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (n_errors == 0)
			$display("block_remap_hash_table_core verification clean");
		else
			$display("block_remap_hash_table_core verification failed");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/brht_pkg.sv
hw/rtl/brht_if.sv
hw/rtl/brht_ram.sv
hw/rtl/brht_front.sv
hw/rtl/brht_engine.sv
hw/rtl/block_remap_hash_table_core.sv
hw/rtl/brht_checker.sv
tb/sv/block_remap_hash_table_core_tb.sv
